[design/crtt_pkg.sv]
// Shared types and constants of the connection retransmit / time-wait timer.
// No dependencies.
package crtt_pkg;

    typedef enum logic [1:0] {
        CMD_TICK         = 2'd0,
        CMD_START_REXMT  = 2'd1,
        CMD_START_TW     = 2'd2,
        CMD_CANCEL_REXMT = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        REG_REXMT_SECONDS = 2'd0,
        REG_RETRY_LIMIT   = 2'd1,
        REG_TW_SECONDS    = 2'd2,
        REG_TICKS_PER_SEC = 2'd3
    } t_reg_idx;

    localparam logic [7:0]  RST_REXMT_SECONDS = 8'd3;
    localparam logic [7:0]  RST_RETRY_LIMIT   = 8'd3;
    localparam logic [15:0] RST_TW_SECONDS    = 16'd60;
    localparam logic [15:0] RST_TICKS_PER_SEC = 16'd100;
    localparam logic [7:0]  RETRY_MAX         = 8'hFF;

    typedef struct packed {
        logic [23:0] rexmt_limit;
        logic [31:0] tw_limit;
        logic [7:0]  retry_limit;
    } t_limits;

    typedef struct packed {
        logic        reschedule;
        logic        retransmit;
        logic [63:0] resend_seq;
        logic        timed_out;
        logic [7:0]  retry_count;
    } t_result;

endpackage

[design/crtt_cfg.sv]
// Configuration registers and registered timeout limits (seconds x tick rate).
// Depends on crtt_pkg.
module crtt_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_wdata,
    output crtt_pkg::t_limits   o_limits
);

    logic [7:0]  r_rexmt_seconds;
    logic [7:0]  r_retry_limit;
    logic [15:0] r_tw_seconds;
    logic [15:0] r_ticks_per_sec;
    crtt_pkg::t_limits r_limits;
    crtt_pkg::t_limits n_limits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rexmt_seconds <= crtt_pkg::RST_REXMT_SECONDS;
            r_retry_limit   <= crtt_pkg::RST_RETRY_LIMIT;
            r_tw_seconds    <= crtt_pkg::RST_TW_SECONDS;
            r_ticks_per_sec <= crtt_pkg::RST_TICKS_PER_SEC;
        end else if (i_cfg_we) begin
            case (crtt_pkg::t_reg_idx'(i_cfg_idx))
                crtt_pkg::REG_REXMT_SECONDS: r_rexmt_seconds <= i_cfg_wdata[7:0];
                crtt_pkg::REG_RETRY_LIMIT:   r_retry_limit   <= i_cfg_wdata[7:0];
                crtt_pkg::REG_TW_SECONDS:    r_tw_seconds    <= i_cfg_wdata;
                crtt_pkg::REG_TICKS_PER_SEC: r_ticks_per_sec <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_limits.rexmt_limit = 24'(r_rexmt_seconds) * 24'(r_ticks_per_sec);
        n_limits.tw_limit    = 32'(r_tw_seconds) * 32'(r_ticks_per_sec);
        n_limits.retry_limit = r_retry_limit;
    end

    always_ff @(posedge i_clk) begin
        r_limits <= n_limits;
    end

    assign o_limits = r_limits;

endmodule

[design/crtt_core.sv]
// Timer state and per-command update logic; one command per step.
// Depends on crtt_pkg.
module crtt_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [1:0]          i_command,
    input  logic [31:0]         i_now_ticks,
    input  logic [63:0]         i_send_next,
    input  logic [63:0]         i_send_unacked,
    input  crtt_pkg::t_limits   i_limits,
    output crtt_pkg::t_result   o_result
);

    logic        r_rexmt_active, n_rexmt_active;
    logic        r_tw_active,    n_tw_active;
    logic [31:0] r_rexmt_start,  n_rexmt_start;
    logic [31:0] r_tw_start,     n_tw_start;
    logic [7:0]  r_retry_count,  n_retry_count;
    logic [63:0] r_saved_seq,    n_saved_seq;
    logic        r_soft_error,   n_soft_error;

    logic [31:0] rexmt_elapsed;
    logic [31:0] tw_elapsed;
    logic        rexmt_overdue;
    logic        tw_overdue;
    logic [63:0] seq_diff;
    logic        una_after;
    logic [7:0]  retry_inc;

    assign rexmt_elapsed = i_now_ticks - r_rexmt_start;
    assign tw_elapsed    = i_now_ticks - r_tw_start;
    assign rexmt_overdue = rexmt_elapsed > 32'(i_limits.rexmt_limit);
    assign tw_overdue    = tw_elapsed > i_limits.tw_limit;
    assign seq_diff      = i_send_unacked - r_saved_seq;
    assign una_after     = (seq_diff != 64'd0) && !seq_diff[63];
    assign retry_inc     = (r_retry_count == crtt_pkg::RETRY_MAX) ? r_retry_count
                                                                  : r_retry_count + 8'd1;

    always_comb begin
        n_rexmt_active = r_rexmt_active;
        n_tw_active    = r_tw_active;
        n_rexmt_start  = r_rexmt_start;
        n_tw_start     = r_tw_start;
        n_retry_count  = r_retry_count;
        n_saved_seq    = r_saved_seq;
        n_soft_error   = r_soft_error;
        o_result       = '0;
        case (crtt_pkg::t_cmd'(i_command))
            crtt_pkg::CMD_TICK: begin
                if (r_rexmt_active && !r_tw_active) begin
                    if (!rexmt_overdue) begin
                        o_result.reschedule = 1'b1;
                    end else if (una_after) begin
                        n_rexmt_active = 1'b0;
                        n_tw_active    = 1'b0;
                        n_saved_seq    = '0;
                    end else begin
                        n_retry_count = retry_inc;
                        if (retry_inc > i_limits.retry_limit) begin
                            n_soft_error = 1'b1;
                        end else begin
                            o_result.retransmit = 1'b1;
                            o_result.resend_seq = r_saved_seq;
                        end
                    end
                end else if (r_tw_active && !r_rexmt_active) begin
                    if (tw_overdue) begin
                        n_soft_error = 1'b1;
                    end else begin
                        o_result.reschedule = 1'b1;
                    end
                end
            end
            crtt_pkg::CMD_START_REXMT: begin
                n_rexmt_active = 1'b1;
                n_rexmt_start  = i_now_ticks;
                n_retry_count  = '0;
                n_saved_seq    = i_send_next;
            end
            crtt_pkg::CMD_START_TW: begin
                n_tw_active = 1'b1;
                n_tw_start  = i_now_ticks;
            end
            default: begin
                n_rexmt_start  = '0;
                n_retry_count  = '0;
                n_rexmt_active = 1'b0;
                n_tw_active    = 1'b0;
            end
        endcase
        o_result.timed_out   = n_soft_error;
        o_result.retry_count = n_retry_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rexmt_active <= 1'b0;
            r_tw_active    <= 1'b0;
            r_rexmt_start  <= '0;
            r_tw_start     <= '0;
            r_retry_count  <= '0;
            r_saved_seq    <= '0;
            r_soft_error   <= 1'b0;
        end else if (i_step) begin
            r_rexmt_active <= n_rexmt_active;
            r_tw_active    <= n_tw_active;
            r_rexmt_start  <= n_rexmt_start;
            r_tw_start     <= n_tw_start;
            r_retry_count  <= n_retry_count;
            r_saved_seq    <= n_saved_seq;
            r_soft_error   <= n_soft_error;
        end
    end

endmodule

[design/connection_retransmit_timewait_timer.sv]
// Top level: input beat register, timer core, result register, config block.
// Depends on crtt_pkg, crtt_cfg, crtt_core.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------------
//  in      | sink      | i_in_valid / o_in_ready    | command, now_ticks, send_next/unacked
//  out     | source    | o_out_valid / i_out_ready  | reschedule, retransmit, resend_seq,
//          |           |                            | timed_out, retry_count_out
//  cfg     | sink      | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_wdata
//
// One beat per cycle sustained unless output stalls (input register, result register).
// The core updates its state as a beat moves from the input to the result register.
// Output stall holds both registers; o_in_ready stays high while the input register
// can drain. Synchronous active-low reset clears timer state and config to defaults.
module connection_retransmit_timewait_timer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_now_ticks,
    input  logic [63:0] i_send_next,
    input  logic [63:0] i_send_unacked,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_reschedule,
    output logic        o_retransmit,
    output logic [63:0] o_resend_seq,
    output logic        o_timed_out,
    output logic [7:0]  o_retry_count_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata
);

    logic              r_in_valid;
    logic [1:0]        r_command;
    logic [31:0]       r_now_ticks;
    logic [63:0]       r_send_next;
    logic [63:0]       r_send_unacked;
    logic              r_out_valid;
    crtt_pkg::t_result r_result;
    crtt_pkg::t_result core_result;
    crtt_pkg::t_limits limits;
    logic              out_free;
    logic              step;
    logic              in_take;

    assign out_free   = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;
    assign in_take    = i_in_valid && o_in_ready;

    crtt_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_limits    (limits)
    );

    crtt_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_command      (r_command),
        .i_now_ticks    (r_now_ticks),
        .i_send_next    (r_send_next),
        .i_send_unacked (r_send_unacked),
        .i_limits       (limits),
        .o_result       (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_command      <= i_command;
            r_now_ticks    <= i_now_ticks;
            r_send_next    <= i_send_next;
            r_send_unacked <= i_send_unacked;
        end
        if (step) begin
            r_result <= core_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_reschedule      = r_result.reschedule;
    assign o_retransmit      = r_result.retransmit;
    assign o_resend_seq      = r_result.resend_seq;
    assign o_timed_out       = r_result.timed_out;
    assign o_retry_count_out = r_result.retry_count;

endmodule

[design/crtt_checker.sv]
// Port-level checks of the timer top level, attached by bind.
// Depends on connection_retransmit_timewait_timer ports only.
module crtt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_reschedule,
    input logic        o_retransmit,
    input logic [63:0] o_resend_seq,
    input logic        o_timed_out
);

    logic r_seen_timeout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_timeout <= 1'b0;
        end else if (o_out_valid && i_out_ready && o_timed_out) begin
            r_seen_timeout <= 1'b1;
        end
    end

    // soft error is sticky until reset
    a_timeout_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_seen_timeout |-> o_timed_out)
        else $error("timed_out dropped after being reported");

    a_resend_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_retransmit && o_reschedule))
        else $error("retransmit and reschedule in one beat");

    a_resend_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_retransmit |-> o_resend_seq == 64'd0)
        else $error("resend_seq nonzero without retransmit");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_resend_seq))
        else $error("stalled output beat changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind connection_retransmit_timewait_timer crtt_checker u_crtt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_reschedule (o_reschedule),
    .o_retransmit (o_retransmit),
    .o_resend_seq (o_resend_seq),
    .o_timed_out  (o_timed_out)
);
